// ----- src/line_substring_filter_unit_macros.svh -----
// Assertion macros shared by the line substring filter RTL
`ifndef LINE_SUBSTRING_FILTER_UNIT_MACROS_SVH
`define LINE_SUBSTRING_FILTER_UNIT_MACROS_SVH
`ifndef SYNTH
// same-cycle implication, checked on every aclk edge outside reset
`define LSF_ASSERT_IMPLIES(name, cond, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error(msg);
// next-cycle implication
`define LSF_ASSERT_NEXT(name, cond, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);
`else
`define LSF_ASSERT_IMPLIES(name, cond, expr, msg)
`define LSF_ASSERT_NEXT(name, cond, expr, msg)
`endif
`endif

// ----- src/lsf_pkg.sv -----
// Types and constants of the line substring filter
`timescale 1ns / 1ps
package lsf_pkg;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int PATTERN_BYTES = 32;
    localparam int PAT_IDX_W     = 5;
    localparam int PAT_REGS      = 4;
    localparam int LEN_W         = 6;
    localparam int COUNT_W       = 8;
    localparam int S_TDATA_W     = 8;
    localparam int M_TDATA_W     = 16;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;
    localparam logic [7:0] NUL_BYTE     = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LENGTH = 3'd0,
        CFG_PATTERN_0_7    = 3'd1,
        CFG_PATTERN_8_15   = 3'd2,
        CFG_PATTERN_16_23  = 3'd3,
        CFG_PATTERN_24_31  = 3'd4
    } cfg_index_t;

    typedef enum logic {
        CMD_DATA = 1'b0,
        CMD_EOF  = 1'b1
    } command_t;

    typedef struct packed {
        logic [LEN_W-1:0]                  length;
        logic [PATTERN_BYTES-1:0][7:0]     bytes;
    } pattern_cfg_t;

    typedef struct packed {
        command_t   command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic               matched;
        logic [COUNT_W-1:0] length;
        logic               truncated;
        logic               at_eof;
    } verdict_t;

endpackage

// ----- src/lsf_cfg_regs.sv -----
// Pattern configuration registers of the line substring filter
`timescale 1ns / 1ps
module lsf_cfg_regs
    import lsf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output pattern_cfg_t          pattern_cfg
);

    logic [LEN_W-1:0]                      length_reg;
    logic [PAT_REGS-1:0][CFG_DATA_W-1:0]   bytes_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_reg <= '0;
            bytes_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PATTERN_LENGTH: length_reg   <= cfg_wdata[LEN_W-1:0];
                CFG_PATTERN_0_7:    bytes_reg[0] <= cfg_wdata;
                CFG_PATTERN_8_15:   bytes_reg[1] <= cfg_wdata;
                CFG_PATTERN_16_23:  bytes_reg[2] <= cfg_wdata;
                CFG_PATTERN_24_31:  bytes_reg[3] <= cfg_wdata;
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    assign pattern_cfg.length = length_reg;
    assign pattern_cfg.bytes  = bytes_reg;

endmodule

// ----- src/lsf_window_match.sv -----
// Recent-byte window, parallel pattern compare and per-line state
`timescale 1ns / 1ps
module lsf_window_match
    import lsf_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int LINE_MAX    = 255
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         item_valid,
    input  item_t        item,
    input  pattern_cfg_t pattern_cfg,
    output logic         verdict_valid,
    output verdict_t     verdict
);

    logic [PATTERN_MAX-1:0][7:0] window_reg, window_next, shifted;
    logic [COUNT_W-1:0]          kept_reg, kept_next, kept_inc;
    logic                        match_reg, match_next;
    logic                        overflow_reg, overflow_next;
    logic [LEN_W-1:0]            used_len;
    logic [PATTERN_MAX-1:0]      hit;
    logic                        window_hit;
    logic                        is_term;
    logic                        keep;

    assign is_term = (item.command == CMD_EOF) || (item.data_byte == NEWLINE_BYTE)
                     || (item.data_byte == NUL_BYTE);
    assign used_len = (pattern_cfg.length > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                                   : pattern_cfg.length;
    assign keep     = kept_reg < COUNT_W'(LINE_MAX);
    assign kept_inc = kept_reg + COUNT_W'(1);

    // newest byte lands at position 0; position j meets pattern byte len-1-j
    always_comb begin
        logic [LEN_W-1:0] pidx;
        pidx = '0;
        shifted[0] = item.data_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            shifted[j] = window_reg[j-1];
        end
        for (int j = 0; j < PATTERN_MAX; j++) begin
            pidx   = used_len - LEN_W'(1) - LEN_W'(j);
            hit[j] = (LEN_W'(j) >= used_len)
                     || (shifted[j] == pattern_cfg.bytes[pidx[PAT_IDX_W-1:0]]);
        end
    end

    assign window_hit = (used_len != '0) && (kept_inc >= COUNT_W'(used_len)) && (&hit);

    always_comb begin
        window_next   = window_reg;
        kept_next     = kept_reg;
        match_next    = match_reg;
        overflow_next = overflow_reg;
        if (item_valid) begin
            if (is_term) begin
                kept_next     = '0;
                match_next    = 1'b0;
                overflow_next = 1'b0;
            end else if (keep) begin
                window_next = shifted;
                kept_next   = kept_inc;
                if (window_hit) begin
                    match_next = 1'b1;
                end
            end else begin
                // drop bytes past the line cap
                overflow_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_reg     <= '0;
            match_reg    <= 1'b0;
            overflow_reg <= 1'b0;
        end else begin
            kept_reg     <= kept_next;
            match_reg    <= match_next;
            overflow_reg <= overflow_next;
        end
    end

    always_ff @(posedge aclk) begin
        window_reg <= window_next;
    end

    assign verdict_valid     = is_term;
    assign verdict.matched   = (kept_reg != '0) && ((used_len == '0) || match_reg);
    assign verdict.length    = kept_reg;
    assign verdict.truncated = overflow_reg;
    assign verdict.at_eof    = (item.command == CMD_EOF);

endmodule

// ----- src/line_substring_filter_unit.sv -----
// Top level of the line substring filter: stream handshake, staging and result register
//
//  channel  | direction | tdata (low bit up)                           | tuser   | tlast
//  ---------+-----------+----------------------------------------------+---------+--------------
//  s_       | in        | data_byte[7:0]                               | command | -
//  m_       | out       | line_matched, line_length[7:0], line_trunc.  | -       | at_end_of_file
//  cfg_     | in        | write enable, register index, 64-bit data    | -       | -
//
// One byte per cycle sustained unless a terminator waits for a free result slot:
// a byte goes from the input register through the window compare into the line
// state registers. Reset is synchronous and clears control state only.
// A pending result stalls only a terminator behind it; data bytes keep flowing.
`timescale 1ns / 1ps
`include "line_substring_filter_unit_macros.svh"
module line_substring_filter_unit
    import lsf_pkg::*;
#(
    parameter int PATTERN_MAX = 32,
    parameter int LINE_MAX    = 255
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                  s_tuser,   // [0] command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // [0] line_matched, [8:1] line_length,
                                             // [9] line_truncated, [15:10] zero
    output logic                  m_tlast,   // at_end_of_file
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    pattern_cfg_t pattern_cfg;
    item_t        in_item_reg;
    logic         in_valid_reg, in_valid_next;
    verdict_t     out_verdict_reg, verdict;
    logic         out_valid_reg, out_valid_next;
    logic         verdict_valid;
    logic         advance;
    logic         s_accept;

    lsf_cfg_regs u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .pattern_cfg (pattern_cfg)
    );

    lsf_window_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .LINE_MAX    (LINE_MAX)
    ) u_match (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .item_valid    (advance),
        .item          (in_item_reg),
        .pattern_cfg   (pattern_cfg),
        .verdict_valid (verdict_valid),
        .verdict       (verdict)
    );

    // a terminator needs a free result slot; data bytes never wait
    assign advance  = in_valid_reg && (!verdict_valid || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance && verdict_valid) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg.command   <= command_t'(s_tuser);
            in_item_reg.data_byte <= s_tdata[7:0];
        end
        if (advance && verdict_valid) begin
            out_verdict_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - COUNT_W - 2){1'b0}}, out_verdict_reg.truncated,
                       out_verdict_reg.length, out_verdict_reg.matched};
    assign m_tlast  = out_verdict_reg.at_eof;

    `LSF_ASSERT_IMPLIES(a_len_capped, m_tvalid, m_tdata[8:1] <= COUNT_W'(LINE_MAX), "line_length above cap")
    `LSF_ASSERT_IMPLIES(a_trunc_full, m_tvalid && m_tdata[9], m_tdata[8:1] == COUNT_W'(LINE_MAX), "truncated line not at full length")
    `LSF_ASSERT_IMPLIES(a_match_nonempty, m_tvalid && m_tdata[0], m_tdata[8:1] != '0, "empty line reported as match")
    `LSF_ASSERT_NEXT(a_verdict_lands, advance && verdict_valid, m_tvalid, "terminator produced no result")

endmodule
